// ----- src/double_ended_queue_top_assert.svh -----
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTH
// Check that a condition holds at every clock edge out of reset.
`define DQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition implies another one in the same cycle.
`define DQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that a condition implies another one in the next cycle.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DQ_ASSERT_ALWAYS(lbl, cond, msg)
`define DQ_ASSERT_SAME(lbl, ante, cons, msg)
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/dq_pkg.sv -----
// Types and constants of the double-ended queue.
package dq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;

  // Request commands on the input channel
  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_VIEW       = 3'd4
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_LISTED = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_FULL   = 2'd2
  } status_t;

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_ROTATE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_VIEW
  } state_t;

endpackage

// ----- src/dq_cell.sv -----
// One storage cell of the queue chain: holds one element and its valid bit.
module dq_cell
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              valid_prev,
  input  logic [DATA_W-1:0] data_prev,
  input  logic              valid_next,
  input  logic [DATA_W-1:0] data_next,
  input  logic [DATA_W-1:0] data_head,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  // Work out the next element and valid bit from the neighbors
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    case (ctl.op)
      OP_PUSH_BACK: begin
        // fill the first empty cell
        if (!valid_r && valid_prev) begin
          valid_nxt = 1'b1;
          data_nxt  = ctl.value;
        end
      end
      OP_PUSH_FRONT: begin
        valid_nxt = valid_prev;
        data_nxt  = data_prev;
      end
      OP_POP_BACK: begin
        valid_nxt = valid_r && valid_next;
      end
      OP_POP_FRONT: begin
        valid_nxt = valid_next;
        data_nxt  = data_next;
      end
      OP_ROTATE: begin
        // advance toward the front, the last full cell takes the head
        if (valid_next) begin
          data_nxt = data_next;
        end else if (valid_r) begin
          data_nxt = data_head;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ----- src/dq_ctrl.sv -----
// Command sequencer, occupancy count and result register of the queue.
`include "double_ended_queue_top_assert.svh"
module dq_ctrl
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cmd_t              in_cmd,
  input  logic [DATA_W-1:0] in_value,
  input  logic [DATA_W-1:0] head_data,
  output cell_ctl_t         cell_ctl,
  output logic              out_tvalid,
  input  logic              out_tready,
  output status_t           out_status,
  output logic [DATA_W-1:0] out_element,
  output logic              out_last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_element_r, out_element_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free;
  logic              accept;
  logic              emit;
  status_t           emit_status;
  logic [DATA_W-1:0] emit_element;
  logic              emit_last;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  // Decode the request, drive the cells and pick the result
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    cell_ctl.op    = OP_NONE;
    cell_ctl.value = in_value;
    emit           = 1'b0;
    emit_status    = STS_LISTED;
    emit_element   = '0;
    emit_last      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
              if (cnt_r == CNT_FULL) begin
                emit        = 1'b1;
                emit_status = STS_FULL;
              end else begin
                cell_ctl.op = (in_cmd == CMD_PUSH_BACK) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                cnt_nxt     = cnt_r + CNT_W'(1);
              end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
              if (cnt_r == '0) begin
                emit        = 1'b1;
                emit_status = STS_EMPTY;
              end else begin
                cell_ctl.op = (in_cmd == CMD_POP_BACK) ? OP_POP_BACK : OP_POP_FRONT;
                cnt_nxt     = cnt_r - CNT_W'(1);
              end
            end
            CMD_VIEW: begin
              if (cnt_r == '0) begin
                emit        = 1'b1;
                emit_status = STS_EMPTY;
              end else begin
                state_nxt = ST_VIEW;
                idx_nxt   = '0;
              end
            end
            default: begin
              // unused codes: drop the request
            end
          endcase
        end
      end
      ST_VIEW: begin
        // list the head and rotate the chain, one element per cycle while the result register is free
        if (out_free) begin
          emit         = 1'b1;
          emit_status  = STS_LISTED;
          emit_element = head_data;
          emit_last    = ((idx_r + CNT_W'(1)) == cnt_r);
          cell_ctl.op  = OP_ROTATE;
          idx_nxt      = idx_r + CNT_W'(1);
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Load the result register when it is free
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    if (out_free) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_status_nxt  = emit_status;
        out_element_nxt = emit_element;
        out_last_nxt    = emit_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

  `DQ_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_FULL, "occupancy above depth")
  `DQ_ASSERT_SAME(a_view_nonempty, state_r == ST_VIEW, cnt_r != '0 && idx_r < cnt_r, "view past end")
  `DQ_ASSERT_SAME(a_view_blocks, state_r == ST_VIEW, !in_tready, "request taken during view")
  `DQ_ASSERT_NEXT(a_pop_count, accept && in_cmd == CMD_POP_FRONT && cnt_r != '0, cnt_r == $past(cnt_r) - CNT_W'(1), "pop did not lower count")

endmodule

// ----- src/double_ended_queue_top.sv -----
// Top level of the double-ended queue: a chain of element cells and its sequencer.
//
//   channel  dir  payload
//   in_      in   tuser[2:0] command, tdata[31:0] value
//   out_     out  tuser[1:0] status, tdata[31:0] element, tlast last
//
// Push and pop leave the sequencer idle; a request may follow in the next cycle if the output register is free.
// View enters the view state, then lists one element per cycle while the chain rotates and the output is free.
// The output register parts the sides; a request is taken only while idle and the register is free or taken.
// Reset clears the occupancy count and the cell valid bits; element data has no reset.
// A low out_tready holds the view rotation and the input until the result leaves.
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] element
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  cell_ctl_t         cell_ctl;
  logic              valid_w [DEPTH];
  logic [DATA_W-1:0] data_w  [DEPTH];
  status_t           out_status;

  // Sequence the requests
  dq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (cmd_t'(in_tuser)),
    .in_value   (in_tdata),
    .head_data  (data_w[0]),
    .cell_ctl   (cell_ctl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_element(out_tdata),
    .out_last   (out_tlast)
  );

  assign out_tuser = out_status;

  // Build the cell chain, front at cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              vp, vn;
    logic [DATA_W-1:0] dp, dn;
    if (i == 0) begin : g_first
      assign vp = 1'b1;
      assign dp = cell_ctl.value;
    end else begin : g_mid
      assign vp = valid_w[i-1];
      assign dp = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign vn = 1'b0;
      assign dn = '0;
    end else begin : g_inner
      assign vn = valid_w[i+1];
      assign dn = data_w[i+1];
    end
    dq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .valid_prev(vp),
      .data_prev (dp),
      .valid_next(vn),
      .data_next (dn),
      .data_head (data_w[0]),
      .valid_o   (valid_w[i]),
      .data_o    (data_w[i])
    );
  end

endmodule
